[rtl/mspm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mspm_pkg;

  localparam int LimbW      = 64;
  localparam int MaxResults = 16;
  localparam int OutIdxW    = 4;
  localparam int OutCntW    = 5;

  typedef struct packed {
    logic [LimbW-1:0] a_limb;
    logic             has_a;
    logic [LimbW-1:0] b_limb;
    logic             has_b;
    logic             last;
  } request_t;

  typedef struct packed {
    logic [LimbW-1:0]   product_limb;
    logic [OutIdxW-1:0] limb_index;
    logic               is_last;
    logic               overflow;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_SUM,
    ST_MAC_ACC,
    ST_ROW_END,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic a_wr;       // store a loaded A limb
    logic b_wr;       // store a loaded B limb
    logic rd_en;      // read A, B and old product limb
    logic mul_en;     // register the four 32x32 partial products
    logic sum_en;     // combine partials into the 128-bit product
    logic acc_en;     // add carry and old limb, write product limb
    logic first_row;  // old product limb counts as zero
    logic first_col;  // row carry counts as zero
    logic carry_wr;   // write the row carry above the row
    logic emit_rd;    // read a product limb for output
    logic zero_prod;  // an operand is empty: product is all zero
  } dp_cmd_t;

endpackage

`default_nettype wire

[rtl/mspm_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module mspm_dp #(
  parameter int MAX_LIMBS = 8,
  parameter int IDX_W     = 3,
  parameter int PIDX_W    = 4
) (
  input  wire logic                         clk,
  input  wire mspm_pkg::dp_cmd_t            cmd,
  input  wire logic [mspm_pkg::LimbW-1:0]   a_limb,
  input  wire logic [mspm_pkg::LimbW-1:0]   b_limb,
  input  wire logic [IDX_W-1:0]             a_addr,
  input  wire logic [IDX_W-1:0]             b_addr,
  input  wire logic [PIDX_W-1:0]            p_addr,
  output logic      [mspm_pkg::LimbW-1:0]   product_limb
);

  localparam int PROD_LIMBS = 2 * MAX_LIMBS;
  localparam int W = mspm_pkg::LimbW;

  logic [W-1:0] a_mem [MAX_LIMBS];
  logic [W-1:0] b_mem [MAX_LIMBS];
  logic [W-1:0] p_mem [PROD_LIMBS];

  logic [W-1:0]   a_rd;
  logic [W-1:0]   b_rd;
  logic [W-1:0]   p_rd;
  logic [W-1:0]   pp00, pp01, pp10, pp11;
  logic [2*W-1:0] prod;
  logic [W-1:0]   carry;

  logic [2*W-1:0] prod_next;
  logic [2*W-1:0] acc_sum;
  logic [W-1:0]   old_limb;
  logic [W-1:0]   carry_in;

  always_ff @(posedge clk) begin
    if (cmd.a_wr) begin
      a_mem[a_addr] <= a_limb;
    end
    if (cmd.rd_en) begin
      a_rd <= a_mem[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.b_wr) begin
      b_mem[b_addr] <= b_limb;
    end
    if (cmd.rd_en) begin
      b_rd <= b_mem[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      p_mem[p_addr] <= acc_sum[W-1:0];
    end else if (cmd.carry_wr) begin
      p_mem[p_addr] <= carry;
    end
    if (cmd.rd_en || cmd.emit_rd) begin
      p_rd <= p_mem[p_addr];
    end
  end

  // Split the 64x64 multiply into four 32x32 products.
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      pp00 <= 64'(a_rd[31:0])  * 64'(b_rd[31:0]);
      pp01 <= 64'(a_rd[31:0])  * 64'(b_rd[63:32]);
      pp10 <= 64'(a_rd[63:32]) * 64'(b_rd[31:0]);
      pp11 <= 64'(a_rd[63:32]) * 64'(b_rd[63:32]);
    end
  end

  assign prod_next = {pp11, pp00} + {32'd0, pp01, 32'd0} + {32'd0, pp10, 32'd0};

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      prod <= prod_next;
    end
  end

  // Product plus two limbs never exceeds 128 bits.
  assign old_limb = cmd.first_row ? '0 : p_rd;
  assign carry_in = cmd.first_col ? '0 : carry;
  assign acc_sum  = prod + {64'd0, carry_in} + {64'd0, old_limb};

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      carry <= acc_sum[2*W-1:W];
    end
  end

  assign product_limb = cmd.zero_prod ? '0 : p_rd;

endmodule

`default_nettype wire

[rtl/mspm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module mspm_ctrl #(
  parameter int MAX_LIMBS = 8,
  parameter int IDX_W     = 3,
  parameter int LEN_W     = 4,
  parameter int PIDX_W    = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            has_a,
  input  wire logic                            has_b,
  input  wire logic                            last,
  output logic                                 busy,
  output logic                                 strobe,
  output logic      [mspm_pkg::OutIdxW-1:0]    limb_index,
  output logic                                 is_last,
  output logic                                 overflow,
  output mspm_pkg::dp_cmd_t                    cmd,
  output logic      [IDX_W-1:0]                a_addr,
  output logic      [IDX_W-1:0]                b_addr,
  output logic      [PIDX_W-1:0]               p_addr
);

  localparam int SUM_W = LEN_W + 1;
  localparam int CW    = mspm_pkg::OutCntW;
  localparam int IW    = mspm_pkg::OutIdxW;

  mspm_pkg::state_t state, state_next;

  logic [LEN_W-1:0]  al, al_next;
  logic [LEN_W-1:0]  bl, bl_next;
  logic              ovf_seen, ovf_seen_next;
  logic [IDX_W-1:0]  i, i_next;
  logic [IDX_W-1:0]  j, j_next;
  logic [PIDX_W-1:0] k, k_next;
  logic [IW-1:0]     out_idx, out_idx_next;
  logic [CW-1:0]     remaining, remaining_next;
  logic              zero_prod, zero_prod_next;
  logic              ovf_out, ovf_out_next;
  logic [SUM_W-1:0]  total;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mspm_pkg::ST_IDLE;
      al        <= '0;
      bl        <= '0;
      ovf_seen  <= 1'b0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      out_idx   <= '0;
      remaining <= '0;
      zero_prod <= 1'b0;
      ovf_out   <= 1'b0;
    end else begin
      state     <= state_next;
      al        <= al_next;
      bl        <= bl_next;
      ovf_seen  <= ovf_seen_next;
      i         <= i_next;
      j         <= j_next;
      k         <= k_next;
      out_idx   <= out_idx_next;
      remaining <= remaining_next;
      zero_prod <= zero_prod_next;
      ovf_out   <= ovf_out_next;
    end
  end

  always_comb begin
    state_next     = state;
    al_next        = al;
    bl_next        = bl;
    ovf_seen_next  = ovf_seen;
    i_next         = i;
    j_next         = j;
    k_next         = k;
    out_idx_next   = out_idx;
    remaining_next = remaining;
    zero_prod_next = zero_prod;
    ovf_out_next   = ovf_out;
    total          = '0;
    cmd            = '0;
    cmd.zero_prod  = zero_prod;
    a_addr         = '0;
    b_addr         = '0;
    p_addr         = '0;
    strobe         = 1'b0;

    case (state)
      mspm_pkg::ST_IDLE: begin
        a_addr = al[IDX_W-1:0];
        b_addr = bl[IDX_W-1:0];
        if (start) begin
          if (has_a) begin
            if (al != LEN_W'(MAX_LIMBS)) begin
              cmd.a_wr = 1'b1;
              al_next  = al + LEN_W'(1);
            end else begin
              ovf_seen_next = 1'b1;
            end
          end
          if (has_b) begin
            if (bl != LEN_W'(MAX_LIMBS)) begin
              cmd.b_wr = 1'b1;
              bl_next  = bl + LEN_W'(1);
            end else begin
              ovf_seen_next = 1'b1;
            end
          end
          if (last) begin
            total = SUM_W'(al_next) + SUM_W'(bl_next);
            if (32'(total) > 32'(mspm_pkg::MaxResults)) begin
              remaining_next = CW'(mspm_pkg::MaxResults);
            end else if (total == '0) begin
              remaining_next = CW'(1);
            end else begin
              remaining_next = CW'(total);
            end
            zero_prod_next = (al_next == '0) || (bl_next == '0);
            ovf_out_next   = ovf_seen_next;
            i_next         = '0;
            j_next         = '0;
            k_next         = '0;
            out_idx_next   = '0;
            if ((al_next == '0) || (bl_next == '0)) begin
              state_next = mspm_pkg::ST_EMIT_RD;
            end else begin
              state_next = mspm_pkg::ST_MAC_RD;
            end
          end
        end
      end
      mspm_pkg::ST_MAC_RD: begin
        a_addr     = j;
        b_addr     = i;
        p_addr     = PIDX_W'(i) + PIDX_W'(j);
        cmd.rd_en  = 1'b1;
        state_next = mspm_pkg::ST_MAC_MUL;
      end
      mspm_pkg::ST_MAC_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = mspm_pkg::ST_MAC_SUM;
      end
      mspm_pkg::ST_MAC_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = mspm_pkg::ST_MAC_ACC;
      end
      mspm_pkg::ST_MAC_ACC: begin
        p_addr        = PIDX_W'(i) + PIDX_W'(j);
        cmd.acc_en    = 1'b1;
        cmd.first_row = (i == '0);
        cmd.first_col = (j == '0);
        if ((LEN_W'(j) + LEN_W'(1)) == al) begin
          state_next = mspm_pkg::ST_ROW_END;
        end else begin
          j_next     = j + IDX_W'(1);
          state_next = mspm_pkg::ST_MAC_RD;
        end
      end
      mspm_pkg::ST_ROW_END: begin
        p_addr       = PIDX_W'(i) + PIDX_W'(al);
        cmd.carry_wr = 1'b1;
        j_next       = '0;
        if ((LEN_W'(i) + LEN_W'(1)) == bl) begin
          state_next = mspm_pkg::ST_EMIT_RD;
        end else begin
          i_next     = i + IDX_W'(1);
          state_next = mspm_pkg::ST_MAC_RD;
        end
      end
      mspm_pkg::ST_EMIT_RD: begin
        p_addr      = k;
        cmd.emit_rd = 1'b1;
        state_next  = mspm_pkg::ST_EMIT_OUT;
      end
      mspm_pkg::ST_EMIT_OUT: begin
        strobe = 1'b1;
        if (remaining == CW'(1)) begin
          al_next       = '0;
          bl_next       = '0;
          ovf_seen_next = 1'b0;
          state_next    = mspm_pkg::ST_IDLE;
        end else begin
          k_next         = k + PIDX_W'(1);
          out_idx_next   = out_idx + IW'(1);
          remaining_next = remaining - CW'(1);
          state_next     = mspm_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_next = mspm_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = (state != mspm_pkg::ST_IDLE);
  assign limb_index = out_idx;
  assign is_last    = (remaining == CW'(1));
  assign overflow   = ovf_out;

  // Loading requests never stall intake.
  a_load_no_stall: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last) |=> !busy)
    else $error("loading request stalled intake");

  // A final request starts work.
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("final request did not start multiplication");

  // The top limb ends the job.
  a_top_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && is_last) |=> !busy)
    else $error("block still busy after top limb");

  // Emission never runs with an exhausted count.
  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    (state == mspm_pkg::ST_EMIT_OUT) |-> (remaining != '0))
    else $error("emit with no limbs remaining");

  // Accumulate always follows the product sum.
  a_acc_order: assert property (@(posedge clk) disable iff (rst)
    (state == mspm_pkg::ST_MAC_ACC) |-> ($past(state) == mspm_pkg::ST_MAC_SUM))
    else $error("accumulate out of order");

endmodule

`default_nettype wire

[rtl/multiprecision_schoolbook_multiply_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Schoolbook multiplier for unsigned integers of up to MAX_LIMBS 64-bit limbs
// per operand. Each request loads an A limb, a B limb or both, least
// significant first, and is taken on any cycle where start is high and busy
// is low; a request without last is absorbed in that cycle and busy stays
// low. A request with last (which may itself carry limbs) raises busy while
// the product is formed and streamed out. Each product limb appears on result
// for exactly one cycle with result_strobe high; there is no backpressure, so
// the receiver must take every limb as it comes. Limbs come least significant
// first, al+bl of them (a single zero limb when both operands are empty, at
// most 16), the top one flagged is_last. Limbs offered beyond MAX_LIMBS are
// dropped and flag overflow on every limb of that product.
// Work after the final request: each multiply-accumulate step passes through
// the single split 64x64 multiplier in turn (read, partial products, combine,
// accumulate), each row of B ends with a step that writes its carry, and each
// emitted limb is read from the product store before it is shown. When an
// operand is empty, the multiply is skipped and only the emission runs.

module multiprecision_schoolbook_multiply_core #(
  parameter int MAX_LIMBS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire mspm_pkg::request_t request,
  output logic                    busy,
  output logic                    result_strobe,
  output mspm_pkg::result_t       result
);

  // Index widths follow from the store depths.
  localparam int IDX_W  = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int LEN_W  = $clog2(MAX_LIMBS + 1);
  localparam int PIDX_W = $clog2(2 * MAX_LIMBS);

  mspm_pkg::dp_cmd_t cmd;
  logic [IDX_W-1:0]  a_addr;
  logic [IDX_W-1:0]  b_addr;
  logic [PIDX_W-1:0] p_addr;

  logic [mspm_pkg::LimbW-1:0]   product_limb;
  logic [mspm_pkg::OutIdxW-1:0] limb_index;
  logic                         is_last;
  logic                         overflow;

  // Sequencer: load counts, row/column loops, emission count.
  mspm_ctrl #(
    .MAX_LIMBS (MAX_LIMBS),
    .IDX_W     (IDX_W),
    .LEN_W     (LEN_W),
    .PIDX_W    (PIDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .has_a      (request.has_a),
    .has_b      (request.has_b),
    .last       (request.last),
    .busy       (busy),
    .strobe     (result_strobe),
    .limb_index (limb_index),
    .is_last    (is_last),
    .overflow   (overflow),
    .cmd        (cmd),
    .a_addr     (a_addr),
    .b_addr     (b_addr),
    .p_addr     (p_addr)
  );

  // Datapath: operand and product stores, split multiplier, accumulator.
  mspm_dp #(
    .MAX_LIMBS (MAX_LIMBS),
    .IDX_W     (IDX_W),
    .PIDX_W    (PIDX_W)
  ) u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .a_limb       (request.a_limb),
    .b_limb       (request.b_limb),
    .a_addr       (a_addr),
    .b_addr       (b_addr),
    .p_addr       (p_addr),
    .product_limb (product_limb)
  );

  // Assemble the result; it is only meaningful while result_strobe is high.
  always_comb begin
    result.product_limb = product_limb;
    result.limb_index   = limb_index;
    result.is_last      = is_last;
    result.overflow     = overflow;
  end

endmodule

`default_nettype wire

[verif/multiprecision_schoolbook_multiply_core_tb.sv]
`timescale 1ns / 1ps

module multiprecision_schoolbook_multiply_core_tb;

  localparam int MaxLimbs       = 8;
  localparam int RandomRequests = 120;
  localparam int CycleLimit     = 400000;
  localparam int DrainCycles    = 20;
  localparam int LimbW          = mspm_pkg::LimbW;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  mspm_pkg::request_t request;
  logic               busy;
  logic               result_strobe;
  mspm_pkg::result_t  result;

  multiprecision_schoolbook_multiply_core #(
    .MAX_LIMBS(MaxLimbs)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .result_strobe(result_strobe),
    .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Operands as the block should hold them between loading requests.
  logic [LimbW-1:0] held_a [MaxLimbs];
  logic [LimbW-1:0] held_b [MaxLimbs];
  int               held_a_len = 0;
  int               held_b_len = 0;
  bit               held_overflow = 1'b0;

  // Product limbs still owed by the block, oldest first.
  mspm_pkg::result_t pending_limbs [$];

  int errors = 0;
  int limbs_checked = 0;
  int products_started = 0;
  int overflow_products = 0;
  int load_requests = 0;
  int cycle_count = 0;
  bit steady = 1'b0;  // set to run a stretch with no idle cycles on start

  // Take one accepted request into the held operands; on a final request form
  // the full product in one wide multiply and queue its limbs.
  task automatic predict_product(input mspm_pkg::request_t req);
    logic [16*LimbW-1:0] a_num;
    logic [16*LimbW-1:0] b_num;
    logic [16*LimbW-1:0] prod;
    mspm_pkg::result_t   limb;
    int                  n;
    // Store limbs up to capacity; anything past it is dropped but remembered.
    if (req.has_a) begin
      if (held_a_len < MaxLimbs) begin
        held_a[held_a_len] = req.a_limb;
        held_a_len++;
      end else begin
        held_overflow = 1'b1;
      end
    end
    if (req.has_b) begin
      if (held_b_len < MaxLimbs) begin
        held_b[held_b_len] = req.b_limb;
        held_b_len++;
      end else begin
        held_overflow = 1'b1;
      end
    end
    if (!req.last) return;
    a_num = '0;
    b_num = '0;
    for (int j = 0; j < held_a_len; j++) a_num[j*LimbW +: LimbW] = held_a[j];
    for (int j = 0; j < held_b_len; j++) b_num[j*LimbW +: LimbW] = held_b[j];
    prod = a_num * b_num;
    // Emit al+bl limbs; two empty operands still give one zero limb.
    n = held_a_len + held_b_len;
    if (n == 0) n = 1;
    if (n > mspm_pkg::MaxResults) n = mspm_pkg::MaxResults;
    for (int k = 0; k < n; k++) begin
      limb.product_limb = prod[k*LimbW +: LimbW];
      limb.limb_index   = k[mspm_pkg::OutIdxW-1:0];
      limb.is_last      = (k == n - 1);
      limb.overflow     = held_overflow;
      pending_limbs.push_back(limb);
    end
    products_started++;
    if (held_overflow) overflow_products++;
    // The block starts the next load empty.
    held_a_len    = 0;
    held_b_len    = 0;
    held_overflow = 1'b0;
  endtask

  // Mostly short gaps, a few long ones, none during a steady stretch.
  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 17) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Favor limbs that stress the carry chain: zero, all ones, one, top bit.
  function automatic logic [LimbW-1:0] pick_limb();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {{(LimbW-1){1'b0}}, 1'b1};
      3: return {1'b1, {(LimbW-1){1'b0}}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Operand length: mostly in range, some empty, some past capacity.
  function automatic int pick_len();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return $urandom_range(MaxLimbs + 1, MaxLimbs + 2);
    return $urandom_range(1, MaxLimbs);
  endfunction

  function automatic mspm_pkg::request_t make_request(
    input logic [LimbW-1:0] a, input bit take_a,
    input logic [LimbW-1:0] b, input bit take_b,
    input bit fin);
    mspm_pkg::request_t req;
    req.a_limb = a;
    req.has_a  = take_a;
    req.b_limb = b;
    req.has_b  = take_b;
    req.last   = fin;
    return req;
  endfunction

  // Offer one request and hold it until the block takes it. Start stays high
  // across back-to-back requests; it only drops when a gap is wanted.
  task automatic send_request(input mspm_pkg::request_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (req.has_a || req.has_b || req.last) load_requests++;
    predict_product(req);
  endtask

  // Load two operands of the given lengths in a random interleave, with an
  // occasional ignored request mixed in. The final limb request usually
  // carries last; otherwise a bare last request follows.
  task automatic load_operands(input int a_len, input int b_len);
    int a_left;
    int b_left;
    bit take_a;
    bit take_b;
    bit fin;
    a_left = a_len;
    b_left = b_len;
    fin    = 1'b0;
    while (a_left > 0 || b_left > 0) begin
      if ($urandom_range(0, 7) == 0)
        send_request(make_request(pick_limb(), 1'b0, pick_limb(), 1'b0, 1'b0));
      take_a = (a_left > 0) && ($urandom_range(0, 2) != 0);
      take_b = (b_left > 0) && ($urandom_range(0, 2) != 0);
      if (!take_a && !take_b) begin
        if (a_left > 0) take_a = 1'b1;
        else take_b = 1'b1;
      end
      a_left -= int'(take_a);
      b_left -= int'(take_b);
      fin = (a_left == 0) && (b_left == 0) && ($urandom_range(0, 3) != 0);
      send_request(make_request(pick_limb(), take_a, pick_limb(), take_b, fin));
    end
    if (!fin) send_request(make_request(pick_limb(), 1'b0, pick_limb(), 1'b0, 1'b1));
  endtask

  // Empty operands: both empty gives one zero limb, one empty gives zeros.
  task automatic test_empty_operands();
    send_request(make_request(pick_limb(), 1'b0, pick_limb(), 1'b0, 1'b1));
    send_request(make_request(pick_limb(), 1'b1, pick_limb(), 1'b0, 1'b0));
    send_request(make_request(pick_limb(), 1'b1, pick_limb(), 1'b0, 1'b1));
    send_request(make_request(pick_limb(), 1'b0, pick_limb(), 1'b1, 1'b1));
  endtask

  // Limb extremes, an ignored request, and the full-size all-ones product
  // that fills every product limb and carries through every row.
  task automatic test_extreme_limbs();
    send_request(make_request(pick_limb(), 1'b0, pick_limb(), 1'b0, 1'b0));
    send_request(make_request('1, 1'b1, '1, 1'b1, 1'b1));
    send_request(make_request('0, 1'b1, {1'b1, {(LimbW-1){1'b0}}}, 1'b1, 1'b1));
    for (int i = 0; i < MaxLimbs; i++)
      send_request(make_request('1, 1'b1, '1, 1'b1, i == MaxLimbs - 1));
  endtask

  // One limb too many on both operands; the extra limbs must be dropped.
  task automatic test_overflow();
    for (int i = 0; i <= MaxLimbs; i++)
      send_request(make_request(pick_limb(), 1'b1, pick_limb(), 1'b1, i == MaxLimbs));
  endtask

  // Mostly well-formed loads of random sizes; one in ten is a lone request
  // with random flags, which may cut a load short or extend the next one.
  task automatic test_random_products();
    int first_count;
    first_count = load_requests;
    while (load_requests - first_count < RandomRequests) begin
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        send_request(make_request(pick_limb(), 1'($urandom_range(0, 1)),
                                  pick_limb(), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1))));
      else
        load_operands(pick_len(), pick_len());
    end
    steady = 1'b0;
  endtask

  // Check every strobed limb against the oldest one owed, field by field.
  always @(posedge clk) begin : check_limbs
    mspm_pkg::result_t want;
    if (!rst && result_strobe) begin
      if (pending_limbs.size() == 0) begin
        $display("%0t: unexpected product limb %h index %0d", $time,
                 result.product_limb, result.limb_index);
        errors++;
      end else begin
        want = pending_limbs.pop_front();
        limbs_checked++;
        if (result.product_limb !== want.product_limb) begin
          $display("%0t: product_limb expected %h got %h", $time,
                   want.product_limb, result.product_limb);
          errors++;
        end
        if (result.limb_index !== want.limb_index) begin
          $display("%0t: limb_index expected %0d got %0d", $time,
                   want.limb_index, result.limb_index);
          errors++;
        end
        if (result.is_last !== want.is_last) begin
          $display("%0t: is_last expected %b got %b", $time, want.is_last, result.is_last);
          errors++;
        end
        if (result.overflow !== want.overflow) begin
          $display("%0t: overflow expected %b got %b", $time, want.overflow, result.overflow);
          errors++;
        end
      end
    end
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d limbs outstanding", $time,
               cycle_count, pending_limbs.size());
      $display("FAIL multiprecision_schoolbook_multiply_core");
      $finish;
    end
  end

  initial begin
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_operands();
    test_extreme_limbs();
    test_overflow();
    test_random_products();

    // Drain: wait for every owed limb and an idle block, then a short tail.
    start <= 1'b0;
    while (pending_limbs.size() != 0 || busy) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Covered %0d loading requests and %0d products (%0d with dropped limbs),",
             load_requests, products_started, overflow_products);
    $display("checking %0d product limbs; %0d mismatches.", limbs_checked, errors);
    if (errors == 0 && pending_limbs.size() == 0) begin
      $display("PASS multiprecision_schoolbook_multiply_core");
    end else begin
      $display("FAIL multiprecision_schoolbook_multiply_core");
    end
    $finish;
  end

endmodule
